### rtl/core/hlcp_pkg.sv
// hlcp_pkg: shared types, field widths and codes for the hop-limited cheapest path block
// no dependencies; imported by every module and interface of the block

package hlcp_pkg;

  localparam int NODE_FIELD_W = 7;
  localparam int EDGE_PRICE_W = 16;
  localparam int NODE_COUNT_W = 8;
  localparam int PRICE_W      = 23;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 8;

  localparam logic [PRICE_W-1:0] PRICE_CAP = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NODE_COUNT = 4'd0,
    REG_SOURCE     = 4'd1,
    REG_DEST       = 4'd2,
    REG_MAX_STOPS  = 4'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_EDGE_RD,
    S_COST_RD,
    S_RELAX,
    S_ROUND_END,
    S_DEST_RD,
    S_DEST_WAIT,
    S_DONE
  } search_state_e;

  typedef struct packed {
    logic [NODE_COUNT_W-1:0] node_count;
    logic [NODE_FIELD_W-1:0] source_node;
    logic [NODE_FIELD_W-1:0] dest_node;
    logic [NODE_FIELD_W-1:0] max_stops;
  } cfg_t;

  typedef struct packed {
    logic               found;
    logic [PRICE_W-1:0] cheapest_price;
  } res_t;

  function automatic logic node_ok(input int unsigned node, input int unsigned count,
                                   input int unsigned max_nodes);
    return (node < count) && (node < max_nodes);
  endfunction

endpackage

### rtl/core/hlcp_edge_if.sv
// hlcp_edge_if: valid/ready channel carrying one edge transaction
// depends on hlcp_pkg

interface hlcp_edge_if;
  import hlcp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    edge_valid;
  logic [NODE_FIELD_W-1:0] from_node;
  logic [NODE_FIELD_W-1:0] to_node;
  logic [EDGE_PRICE_W-1:0] edge_price;
  logic                    last_edge;

  modport source (output valid, edge_valid, from_node, to_node, edge_price, last_edge,
                  input ready);
  modport sink   (input valid, edge_valid, from_node, to_node, edge_price, last_edge,
                  output ready);
endinterface

### rtl/core/hlcp_result_if.sv
// hlcp_result_if: valid/ready channel carrying one search result transaction
// depends on hlcp_pkg

interface hlcp_result_if;
  import hlcp_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [PRICE_W-1:0] cheapest_price;

  modport source (output valid, found, cheapest_price, input ready);
  modport sink   (input valid, found, cheapest_price, output ready);
endinterface

### rtl/core/hlcp_cfg_if.sv
// hlcp_cfg_if: valid/ready register write channel (index and data)
// depends on hlcp_pkg

interface hlcp_cfg_if;
  import hlcp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/hlcp_edge_store.sv
// hlcp_edge_store: edge memory with fill count, one write and one registered read per cycle
// depends on hlcp_pkg

module hlcp_edge_store #(
  parameter int MAX_NODES  = 128,
  parameter int MAX_EDGES  = 4096,
  parameter int PRICE_BITS = 16,
  localparam int NW  = $clog2(MAX_NODES),
  localparam int SW  = (PRICE_BITS < hlcp_pkg::EDGE_PRICE_W) ? PRICE_BITS
                                                            : hlcp_pkg::EDGE_PRICE_W,
  localparam int EW  = $clog2(MAX_EDGES + 1),
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [hlcp_pkg::NODE_FIELD_W-1:0] wr_from_i,
  input  logic [hlcp_pkg::NODE_FIELD_W-1:0] wr_to_i,
  input  logic [hlcp_pkg::EDGE_PRICE_W-1:0] wr_price_i,
  input  logic [hlcp_pkg::NODE_COUNT_W-1:0] node_count_i,
  input  logic                              clear_i,
  input  logic [EAW-1:0]                    rd_addr_i,
  output logic [NW-1:0]                     rd_from_o,
  output logic [NW-1:0]                     rd_to_o,
  output logic [SW-1:0]                     rd_price_o,
  output logic [EW-1:0]                     count_o
);
  import hlcp_pkg::*;

  localparam int ENTRY_W = 2 * NW + SW;

  logic [ENTRY_W-1:0] edge_mem [MAX_EDGES];
  logic [ENTRY_W-1:0] rd_data_q;
  logic [EW-1:0]      count_q;
  logic               store_en;

  assign store_en = wr_en_i
                 && node_ok(32'(wr_from_i), 32'(node_count_i), MAX_NODES)
                 && node_ok(32'(wr_to_i), 32'(node_count_i), MAX_NODES)
                 && (32'(count_q) < MAX_EDGES);

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      edge_mem[count_q[EAW-1:0]] <= {NW'(wr_from_i), NW'(wr_to_i), SW'(wr_price_i)};
    end
    rd_data_q <= edge_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (clear_i) begin
      count_q <= '0;
    end else if (store_en) begin
      count_q <= count_q + EW'(1);
    end
  end

  assign rd_from_o  = rd_data_q[ENTRY_W-1 -: NW];
  assign rd_to_o    = rd_data_q[SW +: NW];
  assign rd_price_o = rd_data_q[SW-1:0];
  assign count_o    = count_q;

endmodule

### rtl/core/hlcp_search.sv
// hlcp_search: sequencer running hop-bounded relaxation rounds over the stored edges
// with one shared saturating add/compare unit and two ping-pong cost memories
// depends on hlcp_pkg; reads the edge store through its registered read port

module hlcp_search #(
  parameter int MAX_NODES  = 128,
  parameter int MAX_EDGES  = 4096,
  parameter int PRICE_BITS = 16,
  localparam int NW  = $clog2(MAX_NODES),
  localparam int SW  = (PRICE_BITS < hlcp_pkg::EDGE_PRICE_W) ? PRICE_BITS
                                                            : hlcp_pkg::EDGE_PRICE_W,
  localparam int EW  = $clog2(MAX_EDGES + 1),
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  hlcp_pkg::cfg_t      cfg_i,
  input  logic [EW-1:0]       edge_cnt_i,
  output logic [EAW-1:0]      edge_addr_o,
  input  logic [NW-1:0]       edge_from_i,
  input  logic [NW-1:0]       edge_to_i,
  input  logic [SW-1:0]       edge_price_i,
  output logic                idle_o,
  output logic                clear_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output hlcp_pkg::res_t      res_o
);
  import hlcp_pkg::*;

  search_state_e state_q, state_d;

  logic [PRICE_W-1:0] cost0_mem [MAX_NODES];
  logic [PRICE_W-1:0] cost1_mem [MAX_NODES];
  logic [PRICE_W-1:0] c0a_q, c0b_q, c1a_q, c1b_q;

  logic [MAX_NODES-1:0]    reached_q, written_q, sel_q;
  logic [EW-1:0]           e_q;
  logic [NODE_FIELD_W-1:0] round_q;
  logic [NW-1:0]           a_q, b_q;
  logic [SW-1:0]           p_q;
  res_t                    res_q;

  logic          src_ok, dst_ok, early_out, edge_ok, last_round;
  logic [NW-1:0] src_idx, dst_idx, rda, rdb, wr_addr;
  logic          wr0_en, wr1_en;
  logic [PRICE_W-1:0] wr_data;

  logic [PRICE_W-1:0] work_val, next_val, sat_sum;
  logic [PRICE_W:0]   sum;
  logic               next_reach, next_bank, upd;

  assign src_ok    = node_ok(32'(cfg_i.source_node), 32'(cfg_i.node_count), MAX_NODES);
  assign dst_ok    = node_ok(32'(cfg_i.dest_node), 32'(cfg_i.node_count), MAX_NODES);
  assign early_out = !src_ok || !dst_ok || (cfg_i.source_node == cfg_i.dest_node);
  assign src_idx   = NW'(cfg_i.source_node);
  assign dst_idx   = NW'(cfg_i.dest_node);
  assign edge_ok   = node_ok(32'(edge_from_i), 32'(cfg_i.node_count), MAX_NODES)
                  && node_ok(32'(edge_to_i), 32'(cfg_i.node_count), MAX_NODES)
                  && reached_q[edge_from_i];
  assign last_round = (round_q == cfg_i.max_stops) || (written_q == '0);

  // shared saturating add and compare
  always_comb begin
    work_val   = sel_q[a_q] ? c1a_q : c0a_q;
    next_bank  = written_q[b_q] ? !sel_q[b_q] : sel_q[b_q];
    next_val   = next_bank ? c1b_q : c0b_q;
    next_reach = reached_q[b_q] | written_q[b_q];
    sum        = {1'b0, work_val} + (PRICE_W + 1)'(p_q);
    sat_sum    = sum[PRICE_W] ? PRICE_CAP : sum[PRICE_W-1:0];
    upd        = !next_reach || (sat_sum < next_val);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = early_out ? S_DONE : S_INIT;
      end
      S_INIT:      state_d = S_EDGE_RD;
      S_EDGE_RD:   state_d = (e_q == edge_cnt_i) ? S_ROUND_END : S_COST_RD;
      S_COST_RD:   state_d = edge_ok ? S_RELAX : S_EDGE_RD;
      S_RELAX:     state_d = S_EDGE_RD;
      S_ROUND_END: state_d = last_round ? S_DEST_RD : S_EDGE_RD;
      S_DEST_RD:   state_d = S_DEST_WAIT;
      S_DEST_WAIT: state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    idle_o      = 1'b0;
    clear_o     = 1'b0;
    res_valid_o = 1'b0;
    wr0_en      = 1'b0;
    wr1_en      = 1'b0;
    wr_addr     = b_q;
    wr_data     = sat_sum;
    rda         = edge_from_i;
    rdb         = edge_to_i;
    case (state_q)
      S_IDLE: idle_o = 1'b1;
      S_INIT: begin
        wr0_en  = 1'b1;
        wr_addr = src_idx;
        wr_data = '0;
      end
      S_RELAX: begin
        wr0_en = upd && sel_q[b_q];
        wr1_en = upd && !sel_q[b_q];
      end
      S_DEST_RD: rda = dst_idx;
      S_DONE: begin
        res_valid_o = 1'b1;
        clear_o     = res_ready_i;
      end
      default: ;
    endcase
  end

  assign edge_addr_o = e_q[EAW-1:0];
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (wr0_en) cost0_mem[wr_addr] <= wr_data;
    if (wr1_en) cost1_mem[wr_addr] <= wr_data;
    c0a_q <= cost0_mem[rda];
    c0b_q <= cost0_mem[rdb];
    c1a_q <= cost1_mem[rda];
    c1b_q <= cost1_mem[rdb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      reached_q <= '0;
      written_q <= '0;
      sel_q     <= '0;
      e_q       <= '0;
      round_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_INIT: begin
          sel_q     <= '0;
          written_q <= '0;
          reached_q <= MAX_NODES'(1) << src_idx;
          e_q       <= '0;
          round_q   <= '0;
        end
        S_COST_RD: begin
          if (!edge_ok) e_q <= e_q + EW'(1);
        end
        S_RELAX: begin
          if (upd) written_q[b_q] <= 1'b1;
          e_q <= e_q + EW'(1);
        end
        S_ROUND_END: begin
          sel_q     <= sel_q ^ written_q;
          reached_q <= reached_q | written_q;
          written_q <= '0;
          e_q       <= '0;
          round_q   <= round_q + NODE_FIELD_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_COST_RD) begin
      a_q <= edge_from_i;
      b_q <= edge_to_i;
      p_q <= edge_price_i;
    end
    if (state_q == S_IDLE && start_i) begin
      res_q.found          <= src_ok && dst_ok;
      res_q.cheapest_price <= '0;
    end else if (state_q == S_DEST_WAIT) begin
      res_q.found          <= reached_q[dst_idx];
      res_q.cheapest_price <= reached_q[dst_idx] ? (sel_q[dst_idx] ? c1a_q : c0a_q) : '0;
    end
  end

endmodule

### rtl/core/hop_limited_cheapest_path.sv
// Hop-limited cheapest path. Edge transactions are taken one per cycle and written to an
// edge memory of MAX_EDGES entries; edges naming a node outside the graph, or arriving once
// the memory is full, are dropped. The transaction marked last starts a search for the least
// total price from source_node to dest_node over at most max_stops+1 edges, after which the
// edge memory is empty again. During the search the input is not ready: a single relaxation
// unit sweeps the stored edges once per round, reading costs and relaxing only for edges
// whose start node is reached, with at most max_stops+1 rounds and an early stop after a
// round that improves nothing. Sums saturate at 8388607. When the source equals the
// destination the answer is found with price 0; out-of-range endpoints give not found. A
// result waits in an output register, so new edges are taken while it is pending.
// Configuration writes are taken every cycle and must only be made while the block is idle.

module hop_limited_cheapest_path #(
  parameter int MAX_NODES  = 128,
  parameter int MAX_EDGES  = 4096,
  parameter int PRICE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hlcp_edge_if.sink     edge_i,
  hlcp_cfg_if.sink      cfg_i,
  hlcp_result_if.source result_o
);
  import hlcp_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int SW  = (PRICE_BITS < EDGE_PRICE_W) ? PRICE_BITS : EDGE_PRICE_W;
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  cfg_t cfg_q;
  res_t out_q, srch_res;
  logic out_valid_q;

  logic          in_accept, srch_idle, srch_clear, res_valid, res_ready;
  logic [EAW-1:0] edge_addr;
  logic [NW-1:0]  er_from, er_to;
  logic [SW-1:0]  er_price;
  logic [EW-1:0]  edge_cnt;

  assign edge_i.ready = srch_idle;
  assign in_accept    = edge_i.valid && edge_i.ready;
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_count  <= NODE_COUNT_W'(1);
      cfg_q.source_node <= '0;
      cfg_q.dest_node   <= '0;
      cfg_q.max_stops   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_NODE_COUNT: cfg_q.node_count  <= NODE_COUNT_W'(cfg_i.data);
        REG_SOURCE:     cfg_q.source_node <= NODE_FIELD_W'(cfg_i.data);
        REG_DEST:       cfg_q.dest_node   <= NODE_FIELD_W'(cfg_i.data);
        REG_MAX_STOPS:  cfg_q.max_stops   <= NODE_FIELD_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  hlcp_edge_store #(
    .MAX_NODES  (MAX_NODES),
    .MAX_EDGES  (MAX_EDGES),
    .PRICE_BITS (PRICE_BITS)
  ) u_edge_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (in_accept && edge_i.edge_valid),
    .wr_from_i    (edge_i.from_node),
    .wr_to_i      (edge_i.to_node),
    .wr_price_i   (edge_i.edge_price),
    .node_count_i (cfg_q.node_count),
    .clear_i      (srch_clear),
    .rd_addr_i    (edge_addr),
    .rd_from_o    (er_from),
    .rd_to_o      (er_to),
    .rd_price_o   (er_price),
    .count_o      (edge_cnt)
  );

  hlcp_search #(
    .MAX_NODES  (MAX_NODES),
    .MAX_EDGES  (MAX_EDGES),
    .PRICE_BITS (PRICE_BITS)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_accept && edge_i.last_edge),
    .cfg_i        (cfg_q),
    .edge_cnt_i   (edge_cnt),
    .edge_addr_o  (edge_addr),
    .edge_from_i  (er_from),
    .edge_to_i    (er_to),
    .edge_price_i (er_price),
    .idle_o       (srch_idle),
    .clear_o      (srch_clear),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (srch_res)
  );

  // output register
  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= srch_res;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.found          = out_q.found;
  assign result_o.cheapest_price = out_q.cheapest_price;

endmodule

### rtl/core/hlcp_checker.sv
// hlcp_checker: port-level assertions for hop_limited_cheapest_path, attached by bind
// depends on hlcp_pkg and the top level's channel interfaces

module hlcp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_last_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         out_found_i,
  input logic [hlcp_pkg::PRICE_W-1:0] out_price_i
);
  import hlcp_pkg::*;

  // result held until the transaction completes
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_found_i) && $stable(out_price_i))
    else $error("result changed while stalled");

  // search keeps the input stalled after the last edge
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input ready right after last edge");

  a_price_when_missing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_found_i |-> out_price_i == '0)
    else $error("nonzero price without a path");

endmodule

bind hop_limited_cheapest_path hlcp_checker u_hlcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (edge_i.valid),
  .in_ready_i  (edge_i.ready),
  .in_last_i   (edge_i.last_edge),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_found_i (result_o.found),
  .out_price_i (result_o.cheapest_price)
);
